>>> sv/fcs_pkg.sv
package fcs_pkg;

  localparam int unsigned CodeRegW = 12;
  localparam int unsigned GainW    = 16;
  localparam int unsigned ScaleW   = 16;
  localparam int unsigned StepW    = 15;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned RefW     = 16;
  localparam int unsigned MeasW    = 16;
  localparam int unsigned CostW    = 18;
  localparam int unsigned NumVec   = 8;
  localparam int unsigned NumOff   = 5;
  localparam int unsigned MidDepth = 4;
  localparam int unsigned OutDepth = 2;

  localparam logic [CostW-1:0] CostMax = 18'h3FFFF;

  typedef enum logic [CfgIdxW-1:0] {
    RegZeroCode    = 8'd0,
    RegCutCode     = 8'd1,
    RegGain        = 8'd2,
    RegCurrentScale = 8'd3,
    RegStepMajor   = 8'd4,
    RegStepMinor   = 8'd5
  } reg_idx_e;

  typedef struct packed {
    logic [CodeRegW-1:0] zero_code;
    logic [CodeRegW-1:0] cut_code;
    logic [GainW-1:0]    gain;
    logic [ScaleW-1:0]   current_scale;
    logic [StepW-1:0]    step_major;
    logic [StepW-1:0]    step_minor;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    zero_code:     12'd2851,
    cut_code:      12'd1862,
    gain:          16'd2466,
    current_scale: 16'd30427,
    step_major:    15'd584,
    step_minor:    15'd293
  };

  typedef enum logic [2:0] {
    OffZero     = 3'd0,
    OffPosMinor = 3'd1,
    OffNegMinor = 3'd2,
    OffPosMajor = 3'd3,
    OffNegMajor = 3'd4
  } off_sel_e;

  localparam off_sel_e VecOff [NumVec][3] = '{
    '{OffZero,     OffZero,     OffZero    },
    '{OffPosMajor, OffNegMinor, OffNegMinor},
    '{OffPosMinor, OffPosMinor, OffNegMajor},
    '{OffNegMinor, OffPosMajor, OffNegMinor},
    '{OffNegMajor, OffPosMinor, OffPosMinor},
    '{OffNegMinor, OffNegMinor, OffPosMajor},
    '{OffPosMinor, OffNegMajor, OffPosMinor},
    '{OffZero,     OffZero,     OffZero    }
  };

  localparam logic [2:0] VecBits [NumVec] = '{
    3'd0, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1, 3'd5, 3'd7
  };

endpackage

>>> sv/fcs_fifo.sv
module fcs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(DEPTH))
    else $error("Queue count exceeds its depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> !empty_o)
    else $error("Queue is empty after a transfer into it.");

endmodule

>>> sv/fcs_front.sv
module fcs_front #(
  parameter int unsigned ADC_BITS     = 12,
  parameter int unsigned CURRENT_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fcs_pkg::cfg_t                       cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [2:0][ADC_BITS-1:0]            code_i,
  input  logic [2:0][fcs_pkg::RefW-1:0]       ref_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [2:0][CURRENT_BITS-1:0]        cur_o,
  output logic [2:0][CURRENT_BITS:0]          scaled_o,
  output logic [2:0][fcs_pkg::RefW-1:0]       ref_o
);

  import fcs_pkg::*;

  localparam int unsigned NumStages = 3;
  localparam int unsigned ProdW     = ADC_BITS + 18;
  localparam int unsigned ShW       = ProdW - 8;
  localparam int unsigned SatW      = (ShW > CURRENT_BITS) ? ShW : CURRENT_BITS;
  localparam int unsigned ScProdW   = CURRENT_BITS + 17;

  localparam logic signed [SatW-1:0] CurHi = SatW'((1 << (CURRENT_BITS - 1)) - 1);
  localparam logic signed [SatW-1:0] CurLo = ~CurHi;

  logic [NumStages-1:0] v_q;
  logic [NumStages:0]   rdy;

  logic [ADC_BITS-1:0] zero_c, cut_c;

  logic signed [ProdW-1:0]        prod_d [3];
  logic signed [ProdW-1:0]        prod_q [3];
  logic                           ov_d [3];
  logic                           ov_q [3];
  logic [RefW-1:0]                ref0_q [3];

  logic signed [SatW-1:0]         sh [3];
  logic signed [CURRENT_BITS-1:0] cur1_d [3];
  logic signed [CURRENT_BITS-1:0] cur1_q [3];
  logic [RefW-1:0]                ref1_q [3];

  logic signed [ScProdW-1:0]      scp [3];
  logic signed [CURRENT_BITS-1:0] cur2_q [3];
  logic signed [CURRENT_BITS:0]   sc2_q [3];
  logic [RefW-1:0]                ref2_q [3];

  assign zero_c = ADC_BITS'(cfg_i.zero_code);
  assign cut_c  = ADC_BITS'(cfg_i.cut_code);

  assign rdy[3] = out_ready_i;
  assign rdy[2] = !v_q[2] || rdy[3];
  assign rdy[1] = !v_q[1] || rdy[2];
  assign rdy[0] = !v_q[0] || rdy[1];

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NumStages-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_d[i] = ($signed({1'b0, code_i[i]}) - $signed({1'b0, zero_c}))
                  * $signed({1'b0, cfg_i.gain});
      ov_d[i]   = (code_i[i] > cut_c);
      sh[i]     = SatW'(prod_q[i] >>> 8);
      if (!ov_q[i]) begin
        cur1_d[i] = '0;
      end else if (sh[i] > CurHi) begin
        cur1_d[i] = CurHi[CURRENT_BITS-1:0];
      end else if (sh[i] < CurLo) begin
        cur1_d[i] = CurLo[CURRENT_BITS-1:0];
      end else begin
        cur1_d[i] = sh[i][CURRENT_BITS-1:0];
      end
      scp[i] = cur1_q[i] * $signed({1'b0, cfg_i.current_scale});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (rdy[0]) begin
        prod_q[i] <= prod_d[i];
        ov_q[i]   <= ov_d[i];
        ref0_q[i] <= ref_i[i];
      end
      if (rdy[1]) begin
        cur1_q[i] <= cur1_d[i];
        ref1_q[i] <= ref0_q[i];
      end
      if (rdy[2]) begin
        cur2_q[i] <= cur1_q[i];
        sc2_q[i]  <= scp[i][CURRENT_BITS+15:15];
        ref2_q[i] <= ref1_q[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cur_o[i]    = cur2_q[i];
      scaled_o[i] = sc2_q[i];
      ref_o[i]    = ref2_q[i];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NumStages-1] && !out_ready_i) |=> v_q[NumStages-1])
    else $error("Converted item was dropped while the queue was full.");

endmodule

>>> sv/fcs_back.sv
module fcs_back #(
  parameter int unsigned CURRENT_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fcs_pkg::cfg_t                   cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [2:0][CURRENT_BITS-1:0]    cur_i,
  input  logic [2:0][CURRENT_BITS:0]      scaled_i,
  input  logic [2:0][fcs_pkg::RefW-1:0]   ref_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      sw_o,
  output logic [fcs_pkg::CostW-1:0]       cost_o,
  output logic [2:0][fcs_pkg::MeasW-1:0]  meas_o
);

  import fcs_pkg::*;

  localparam int unsigned NumStages = 5;
  localparam int unsigned DW = ((CURRENT_BITS + 1 > RefW) ? CURRENT_BITS + 1 : RefW) + 1;
  localparam int unsigned EW = DW + 1;
  localparam int unsigned CW = EW + 2;

  logic [NumStages-1:0] v_q;
  logic [NumStages:0]   rdy;

  logic signed [DW-1:0] d0_d [3];
  logic signed [DW-1:0] d0_q [3];
  logic [MeasW-1:0]     meas0_q [3];

  logic signed [EW-1:0] offv [NumOff];
  logic signed [EW-1:0] x [3][NumOff];
  logic [EW-1:0]        e1_d [3][NumOff];
  logic [EW-1:0]        e1_q [3][NumOff];
  logic [MeasW-1:0]     meas1_q [3];

  logic [CW-1:0]        sum [NumVec];
  logic [CostW-1:0]     cost2_d [NumVec];
  logic [CostW-1:0]     cost2_q [NumVec];
  logic [MeasW-1:0]     meas2_q [3];

  logic [CostW-1:0]     l1c_d [4];
  logic [2:0]           l1b_d [4];
  logic [CostW-1:0]     l1c_q [4];
  logic [2:0]           l1b_q [4];
  logic [MeasW-1:0]     meas3_q [3];

  logic [CostW-1:0]     c01, c23, best_cost_d, best_cost_q;
  logic [2:0]           b01, b23, best_bits_d, best_bits_q;
  logic [MeasW-1:0]     meas4_q [3];

  assign rdy[5] = out_ready_i;
  assign rdy[4] = !v_q[4] || rdy[5];
  assign rdy[3] = !v_q[3] || rdy[4];
  assign rdy[2] = !v_q[2] || rdy[3];
  assign rdy[1] = !v_q[1] || rdy[2];
  assign rdy[0] = !v_q[0] || rdy[1];

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NumStages-1];

  always_comb begin
    offv[OffZero]     = '0;
    offv[OffPosMinor] = EW'($signed({1'b0, cfg_i.step_minor}));
    offv[OffNegMinor] = -EW'($signed({1'b0, cfg_i.step_minor}));
    offv[OffPosMajor] = EW'($signed({1'b0, cfg_i.step_major}));
    offv[OffNegMajor] = -EW'($signed({1'b0, cfg_i.step_major}));
    for (int i = 0; i < 3; i++) begin
      d0_d[i] = DW'($signed(ref_i[i])) - DW'($signed(scaled_i[i]));
      for (int o = 0; o < NumOff; o++) begin
        x[i][o]    = EW'(d0_q[i]) - offv[o];
        e1_d[i][o] = x[i][o][EW-1] ? -x[i][o] : x[i][o];
      end
    end
    for (int k = 0; k < NumVec; k++) begin
      sum[k] = CW'(e1_q[0][VecOff[k][0]]) + CW'(e1_q[1][VecOff[k][1]])
             + CW'(e1_q[2][VecOff[k][2]]);
      cost2_d[k] = (sum[k] > CW'(CostMax)) ? CostMax : sum[k][CostW-1:0];
    end
    for (int p = 0; p < 4; p++) begin
      if (cost2_q[2*p+1] < cost2_q[2*p]) begin
        l1c_d[p] = cost2_q[2*p+1];
        l1b_d[p] = VecBits[2*p+1];
      end else begin
        l1c_d[p] = cost2_q[2*p];
        l1b_d[p] = VecBits[2*p];
      end
    end
    if (l1c_q[1] < l1c_q[0]) begin
      c01 = l1c_q[1];
      b01 = l1b_q[1];
    end else begin
      c01 = l1c_q[0];
      b01 = l1b_q[0];
    end
    if (l1c_q[3] < l1c_q[2]) begin
      c23 = l1c_q[3];
      b23 = l1b_q[3];
    end else begin
      c23 = l1c_q[2];
      b23 = l1b_q[2];
    end
    if (c23 < c01) begin
      best_cost_d = c23;
      best_bits_d = b23;
    end else begin
      best_cost_d = c01;
      best_bits_d = b01;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
      if (rdy[4]) v_q[4] <= v_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      for (int i = 0; i < 3; i++) begin
        d0_q[i]    <= d0_d[i];
        meas0_q[i] <= MeasW'($signed(cur_i[i]));
      end
    end
    if (rdy[1]) begin
      e1_q    <= e1_d;
      meas1_q <= meas0_q;
    end
    if (rdy[2]) begin
      cost2_q <= cost2_d;
      meas2_q <= meas1_q;
    end
    if (rdy[3]) begin
      l1c_q   <= l1c_d;
      l1b_q   <= l1b_d;
      meas3_q <= meas2_q;
    end
    if (rdy[4]) begin
      best_cost_q <= best_cost_d;
      best_bits_q <= best_bits_d;
      meas4_q     <= meas3_q;
    end
  end

  assign sw_o   = best_bits_q;
  assign cost_o = best_cost_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      meas_o[i] = meas4_q[i];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[3] && rdy[4]) |=> (best_cost_q <= $past(l1c_q[0])))
    else $error("Selected cost exceeds the cost of the first vector pair.");

endmodule

>>> sv/fcs_predictive_current_selector_unit.sv
// Channel  Handshake                  Payload
// input    push / full                code_a_i..code_c_i, ref_a_i..ref_c_i
// result   empty / pop                sw_a_o..sw_c_o, best_cost_o, meas_a_o..meas_c_o
// config   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item is taken per cycle while full is low; on its way to being readable, it passes
// through the three-stage conversion pipeline, the four-entry queue,
// the five-stage cost and selection pipeline and the result queue.
// Reset restores the register defaults and empties every stage and queue.
// A result left waiting backs up through both pipelines before full rises.
module fcs_predictive_current_selector_unit #(
  parameter int unsigned ADC_BITS     = 12,
  parameter int unsigned CURRENT_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fcs_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [fcs_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic [ADC_BITS-1:0]            code_a_i,
  input  logic [ADC_BITS-1:0]            code_b_i,
  input  logic [ADC_BITS-1:0]            code_c_i,
  input  logic signed [fcs_pkg::RefW-1:0] ref_a_i,
  input  logic signed [fcs_pkg::RefW-1:0] ref_b_i,
  input  logic signed [fcs_pkg::RefW-1:0] ref_c_i,
  output logic                           empty,
  input  logic                           pop,
  output logic                           sw_a_o,
  output logic                           sw_b_o,
  output logic                           sw_c_o,
  output logic [fcs_pkg::CostW-1:0]      best_cost_o,
  output logic signed [fcs_pkg::MeasW-1:0] meas_a_o,
  output logic signed [fcs_pkg::MeasW-1:0] meas_b_o,
  output logic signed [fcs_pkg::MeasW-1:0] meas_c_o
);

  import fcs_pkg::*;

  localparam int unsigned MidW = 3 * CURRENT_BITS + 3 * (CURRENT_BITS + 1) + 3 * RefW;
  localparam int unsigned OutW = 3 + CostW + 3 * MeasW;

  cfg_t cfg_q;

  logic                         f_in_ready, f_out_valid;
  logic [2:0][CURRENT_BITS-1:0] f_cur, m_cur;
  logic [2:0][CURRENT_BITS:0]   f_scaled, m_scaled;
  logic [2:0][RefW-1:0]         f_ref, m_ref;

  logic            mid_full, mid_empty;
  logic [MidW-1:0] mid_wdata, mid_rdata;

  logic                  b_in_ready, b_out_valid;
  logic [2:0]            b_sw, o_sw;
  logic [CostW-1:0]      b_cost, o_cost;
  logic [2:0][MeasW-1:0] b_meas, o_meas;

  logic            out_full;
  logic [OutW-1:0] out_wdata, out_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegZeroCode:     cfg_q.zero_code     <= cfg_data_i[CodeRegW-1:0];
        RegCutCode:      cfg_q.cut_code      <= cfg_data_i[CodeRegW-1:0];
        RegGain:         cfg_q.gain          <= cfg_data_i[GainW-1:0];
        RegCurrentScale: cfg_q.current_scale <= cfg_data_i[ScaleW-1:0];
        RegStepMajor:    cfg_q.step_major    <= cfg_data_i[StepW-1:0];
        RegStepMinor:    cfg_q.step_minor    <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  assign full = !f_in_ready;

  fcs_front #(
    .ADC_BITS     (ADC_BITS),
    .CURRENT_BITS (CURRENT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (push),
    .in_ready_o  (f_in_ready),
    .code_i      ({code_c_i, code_b_i, code_a_i}),
    .ref_i       ({ref_c_i, ref_b_i, ref_a_i}),
    .out_valid_o (f_out_valid),
    .out_ready_i (!mid_full),
    .cur_o       (f_cur),
    .scaled_o    (f_scaled),
    .ref_o       (f_ref)
  );

  assign mid_wdata = {f_cur, f_scaled, f_ref};
  assign {m_cur, m_scaled, m_ref} = mid_rdata;

  fcs_fifo #(
    .WIDTH (MidW),
    .DEPTH (MidDepth)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_out_valid),
    .data_i  (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (b_in_ready),
    .data_o  (mid_rdata),
    .empty_o (mid_empty)
  );

  fcs_back #(
    .CURRENT_BITS (CURRENT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (!mid_empty),
    .in_ready_o  (b_in_ready),
    .cur_i       (m_cur),
    .scaled_i    (m_scaled),
    .ref_i       (m_ref),
    .out_valid_o (b_out_valid),
    .out_ready_i (!out_full),
    .sw_o        (b_sw),
    .cost_o      (b_cost),
    .meas_o      (b_meas)
  );

  assign out_wdata = {b_sw, b_cost, b_meas};
  assign {o_sw, o_cost, o_meas} = out_rdata;

  fcs_fifo #(
    .WIDTH (OutW),
    .DEPTH (OutDepth)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b_out_valid),
    .data_i  (out_wdata),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_rdata),
    .empty_o (empty)
  );

  assign sw_a_o      = o_sw[2];
  assign sw_b_o      = o_sw[1];
  assign sw_c_o      = o_sw[0];
  assign best_cost_o = o_cost;
  assign meas_a_o    = o_meas[0];
  assign meas_b_o    = o_meas[1];
  assign meas_c_o    = o_meas[2];

endmodule
